>>> hdl/plbq_pkg.sv
// Package for the proximity log-barrier block: constants, result types and
// the 48-bit saturation helper. No dependencies.
package plbq_pkg;

  localparam int DIV_QW    = 49;
  localparam int DIV_LAT   = DIV_QW + 1;
  localparam int LOG_FRAC  = 24;
  localparam int LOG_LAT   = LOG_FRAC + 5;
  localparam int COST_DLY  = DIV_LAT - LOG_LAT;
  localparam int FRONT_LAT = 7;
  localparam int PIPE_LAT  = FRONT_LAT + DIV_LAT;

  localparam int CFG_IW = 2;
  localparam logic [CFG_IW-1:0] REG_WEIGHT = 2'd0;
  localparam logic [CFG_IW-1:0] REG_THRESH = 2'd1;

  localparam logic [31:0] WEIGHT_RST = 32'd65536;
  localparam logic [47:0] THRESH_RST = 48'd65536;
  localparam logic [31:0] LN2_Q32    = 32'd2977044472;

  typedef struct packed {
    logic [47:0] cost;
    logic [47:0] hess_xx;
    logic [47:0] hess_yy;
    logic [47:0] hess_xy;
    logic [47:0] grad_x;
    logic [47:0] grad_y;
    logic        gap_invalid;
  } res_t;

  typedef struct packed {
    logic inv;
    logic dneg;
    logic eneg;
    logic dzero;
    logic ezero;
  } side_t;

  function automatic logic [47:0] sat48(input logic neg, input logic [48:0] mag);
    logic [48:0] cap;
    logic [47:0] v;
    cap = neg ? 49'h0_8000_0000_0000 : 49'h0_7FFF_FFFF_FFFF;
    v = (mag > cap) ? cap[47:0] : mag[47:0];
    return neg ? (~v + 48'd1) : v;
  endfunction

endpackage

>>> hdl/plbq_if.sv
// Channel interfaces for the proximity log-barrier block: item input,
// result output and register write. Depends on plbq_pkg.
interface plbq_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] first_x;
  logic signed [31:0] first_y;
  logic signed [31:0] second_x;
  logic signed [31:0] second_y;
  modport source(output valid, first_x, first_y, second_x, second_y, input ready);
  modport sink(input valid, first_x, first_y, second_x, second_y, output ready);
endinterface

interface plbq_out_if;
  logic               valid;
  logic               ready;
  logic signed [47:0] cost;
  logic signed [47:0] hess_xx;
  logic signed [47:0] hess_yy;
  logic signed [47:0] hess_xy;
  logic signed [47:0] grad_x;
  logic signed [47:0] grad_y;
  logic               gap_invalid;
  modport source(output valid, cost, hess_xx, hess_yy, hess_xy, grad_x, grad_y,
                 gap_invalid, input ready);
  modport sink(input valid, cost, hess_xx, hess_yy, hess_xy, grad_x, grad_y,
               gap_invalid, output ready);
endinterface

interface plbq_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [plbq_pkg::CFG_IW-1:0]   index;
  logic [47:0]                   data;
  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

>>> hdl/plbq_div.sv
// Pipelined restoring divider, one quotient bit per stage, quotient clamped
// to all ones on overflow. Depends on nothing outside itself.
module plbq_div #(
  parameter int NW = 64,
  parameter int DW = 50,
  parameter int QW = 49
) (
  input  logic          clk,
  input  logic          en,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  output logic [QW-1:0] quo
);

  localparam int CW = (NW - QW > DW) ? NW - QW : DW;

  logic [DW-1:0] rem [0:QW-1];
  logic [QW-1:0] low [0:QW-1];
  logic [DW-1:0] dd  [0:QW-1];
  logic [QW-1:0] qs  [0:QW];
  logic [QW:0]   ovf;

  always_ff @(posedge clk) begin
    if (en) begin
      rem[0] <= DW'(num[NW-1:QW]);
      low[0] <= num[QW-1:0];
      dd[0]  <= den;
      qs[0]  <= '0;
      ovf[0] <= CW'(num[NW-1:QW]) >= CW'(den);
    end
  end

  for (genvar k = 1; k <= QW; k++) begin : g_step
    logic [DW:0]   t;
    logic          qb;
    logic [DW-1:0] rn;
    assign t  = {rem[k-1], low[k-1][QW-1]};
    assign qb = t >= {1'b0, dd[k-1]};
    assign rn = qb ? DW'(t - {1'b0, dd[k-1]}) : t[DW-1:0];
    always_ff @(posedge clk) begin
      if (en) begin
        qs[k]  <= {qs[k-1][QW-2:0], qb};
        ovf[k] <= ovf[k-1];
      end
    end
    if (k < QW) begin : g_carry
      always_ff @(posedge clk) begin
        if (en) begin
          rem[k] <= rn;
          low[k] <= {low[k-1][QW-2:0], 1'b0};
          dd[k]  <= dd[k-1];
        end
      end
    end
  end

  assign quo = ovf[QW] ? '1 : qs[QW];

endmodule

>>> hdl/plbq_log.sv
// Pipelined barrier cost: leading-one normalize, squaring stages for the
// log2 fraction, ln2 scaling and weight product. Depends on plbq_pkg.
module plbq_log (
  input  logic        clk,
  input  logic        en,
  input  logic [49:0] g,
  input  logic [31:0] w,
  output logic [47:0] cost
);
  import plbq_pkg::*;

  logic [5:0]          p_lead;
  logic [49:0]         g1;
  logic [31:0]         w1;
  logic [5:0]          p1;
  logic [30:0]         ms [0:LOG_FRAC];
  logic [LOG_FRAC-1:0] fr [0:LOG_FRAC];
  logic [5:0]          pp [0:LOG_FRAC];
  logic [31:0]         ww [0:LOG_FRAC];
  logic signed [31:0]  l;
  logic                lneg27, lneg28, neg29;
  logic [30:0]         lmag27, lnm28;
  logic [31:0]         w27, w28;
  logic [37:0]         cm29;

  always_comb begin
    p_lead = '0;
    for (int i = 0; i < 50; i++) begin
      if (g[i]) begin
        p_lead = 6'(i);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      g1    <= g;
      w1    <= w;
      p1    <= p_lead;
      ms[0] <= (p1 <= 6'd30) ? 31'(g1 << (6'd30 - p1)) : 31'(g1 >> (p1 - 6'd30));
      fr[0] <= '0;
      pp[0] <= p1;
      ww[0] <= w1;
    end
  end

  for (genvar k = 1; k <= LOG_FRAC; k++) begin : g_sq
    logic [61:0] sq;
    logic [31:0] t;
    assign sq = 62'(ms[k-1]) * 62'(ms[k-1]);
    assign t  = sq[61:30];
    always_ff @(posedge clk) begin
      if (en) begin
        ms[k] <= t[31] ? t[31:1] : t[30:0];
        fr[k] <= {fr[k-1][LOG_FRAC-2:0], t[31]};
        pp[k] <= pp[k-1];
        ww[k] <= ww[k-1];
      end
    end
  end

  assign l = (($signed({26'b0, pp[LOG_FRAC]}) - 32'sd16) <<< LOG_FRAC)
             + $signed({{(32 - LOG_FRAC){1'b0}}, fr[LOG_FRAC]});

  always_ff @(posedge clk) begin
    if (en) begin
      lneg27 <= l[31];
      lmag27 <= 31'(l[31] ? -l : l);
      w27    <= ww[LOG_FRAC];
      lneg28 <= lneg27;
      lnm28  <= 31'((63'(lmag27) * 63'(LN2_Q32)) >> 32);
      w28    <= w27;
      neg29  <= !lneg28 && (lnm28 != '0);
      cm29   <= 38'((63'(w28) * 63'(lnm28)) >> 25);
    end
  end

  assign cost = sat48(neg29, 49'(cm29));

endmodule

>>> hdl/proximity_log_barrier_quadratic.sv
// Top level of the proximity log-barrier evaluator: front arithmetic, six
// pipelined dividers, the log unit and a two-entry output buffer.
// Depends on plbq_pkg, plbq_if, plbq_div and plbq_log.
//
//   channel  dir  transfer when          payload
//   pos      in   pos.valid & pos.ready  first_x, first_y, second_x, second_y
//   res      out  res.valid & res.ready  cost, hess_*, grad_*, gap_invalid
//   cfg      in   cfg.valid & cfg.ready  index, data
//
// One item per cycle while the output buffer has room; a result reaches the
// output buffer via seven arithmetic stages, then 50 stages set by the 49-bit
// restoring dividers (the log unit runs alongside them).
// rst is synchronous and clears the stage valid bits, the buffer and the
// registers (weight and threshold back to 1.0). The pipeline advances
// whenever the output buffer holds fewer than two results; cfg is always ready.
module proximity_log_barrier_quadratic (
  input  logic        clk,
  input  logic        rst,
  plbq_in_if.sink     pos,
  plbq_out_if.source  res,
  plbq_cfg_if.sink    cfg
);
  import plbq_pkg::*;

  logic [31:0] weight;
  logic [47:0] threshold_sq;
  logic        en;
  logic [PIPE_LAT-1:0] vp;

  logic signed [32:0] s1_d, s1_e;
  logic [32:0] s2_ad, s2_ae;
  logic        s2_dn, s2_en;
  logic [64:0] s3_d2, s3_e2, s3_dxy;
  logic [63:0] s3_wad, s3_wae;
  logic        s3_dn, s3_en, s3_dz, s3_ez;
  logic [65:0] s3_sum;
  logic [49:0] s4_s16;
  logic [63:0] s4_xx_lo, s4_yy_lo, s4_xy_lo, s4_wad, s4_wae;
  logic [64:0] s4_xx_hi, s4_yy_hi, s4_xy_hi;
  logic        s4_dn, s4_en, s4_dz, s4_ez;
  logic [96:0] s4_sxx, s4_syy, s4_sxy;
  logic [49:0] s5_g;
  logic [97:0] s5_nxx, s5_nyy, s5_nxy;
  logic [63:0] s5_wad, s5_wae;
  side_t       s5_sd;
  logic [49:0] s6_g, s6_phh, s6_phl, s6_pll;
  logic [97:0] s6_nxx, s6_nyy, s6_nxy;
  logic [63:0] s6_wad, s6_wae;
  side_t       s6_sd;
  logic [49:0] s7_g;
  logic [99:0] s7_g2;
  logic [97:0] s7_nxx, s7_nyy, s7_nxy;
  logic [63:0] s7_wad, s7_wae;
  side_t       s7_sd;
  side_t       sd [1:DIV_LAT];

  logic [DIV_QW-1:0] q_xx, q_yy, q_xy, q_gx, q_gy, q_w;
  logic [47:0] cost_log;
  logic [47:0] cd [0:COST_DLY-1];
  logic [47:0] hx, hy;
  res_t        fin, buf0, buf1;
  logic [1:0]  cnt;
  logic        push, pop;
  side_t       sl;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      weight       <= WEIGHT_RST;
      threshold_sq <= THRESH_RST;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        REG_WEIGHT: weight       <= cfg.data[31:0];
        REG_THRESH: threshold_sq <= cfg.data;
        default: ;
      endcase
    end
  end

  assign en        = ~cnt[1];
  assign pos.ready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      vp <= '0;
    end else if (en) begin
      vp <= {vp[PIPE_LAT-2:0], pos.valid};
    end
  end

  assign s3_sum = 66'(s3_d2) + 66'(s3_e2);
  assign s4_sxx = {s4_xx_hi, 32'b0} + 97'(s4_xx_lo);
  assign s4_syy = {s4_yy_hi, 32'b0} + 97'(s4_yy_lo);
  assign s4_sxy = {s4_xy_hi, 32'b0} + 97'(s4_xy_lo);

  always_ff @(posedge clk) begin
    if (en) begin
      s1_d <= $signed({pos.first_x[31], pos.first_x})
              - $signed({pos.second_x[31], pos.second_x});
      s1_e <= $signed({pos.first_y[31], pos.first_y})
              - $signed({pos.second_y[31], pos.second_y});

      s2_dn <= s1_d[32];
      s2_en <= s1_e[32];
      s2_ad <= s1_d[32] ? 33'(-s1_d) : 33'(s1_d);
      s2_ae <= s1_e[32] ? 33'(-s1_e) : 33'(s1_e);

      s3_d2  <= 65'(s2_ad) * 65'(s2_ad);
      s3_e2  <= 65'(s2_ae) * 65'(s2_ae);
      s3_dxy <= 65'(s2_ad) * 65'(s2_ae);
      s3_wad <= 64'(weight) * 64'(s2_ad);
      s3_wae <= 64'(weight) * 64'(s2_ae);
      s3_dn  <= s2_dn;
      s3_en  <= s2_en;
      s3_dz  <= s2_ad == '0;
      s3_ez  <= s2_ae == '0;

      s4_s16   <= s3_sum[65:16];
      s4_xx_lo <= 64'(weight) * 64'(s3_d2[31:0]);
      s4_yy_lo <= 64'(weight) * 64'(s3_e2[31:0]);
      s4_xy_lo <= 64'(weight) * 64'(s3_dxy[31:0]);
      s4_xx_hi <= 65'(weight) * 65'(s3_d2[64:32]);
      s4_yy_hi <= 65'(weight) * 65'(s3_e2[64:32]);
      s4_xy_hi <= 65'(weight) * 65'(s3_dxy[64:32]);
      s4_wad   <= s3_wad;
      s4_wae   <= s3_wae;
      s4_dn    <= s3_dn;
      s4_en    <= s3_en;
      s4_dz    <= s3_dz;
      s4_ez    <= s3_ez;

      s5_g   <= s4_s16 - 50'(threshold_sq);
      s5_sd  <= '{inv: s4_s16 <= 50'(threshold_sq), dneg: s4_dn, eneg: s4_en,
                  dzero: s4_dz, ezero: s4_ez};
      s5_nxx <= {s4_sxx, 1'b0};
      s5_nyy <= {s4_syy, 1'b0};
      s5_nxy <= {s4_sxy, 1'b0};
      s5_wad <= s4_wad;
      s5_wae <= s4_wae;

      s6_phh <= 50'(s5_g[49:25]) * 50'(s5_g[49:25]);
      s6_phl <= 50'(s5_g[49:25]) * 50'(s5_g[24:0]);
      s6_pll <= 50'(s5_g[24:0]) * 50'(s5_g[24:0]);
      s6_g   <= s5_g;
      s6_sd  <= s5_sd;
      s6_nxx <= s5_nxx;
      s6_nyy <= s5_nyy;
      s6_nxy <= s5_nxy;
      s6_wad <= s5_wad;
      s6_wae <= s5_wae;

      s7_g2  <= (100'(s6_phh) << 50) + (100'(s6_phl) << 26) + 100'(s6_pll);
      s7_g   <= s6_g;
      s7_sd  <= s6_sd;
      s7_nxx <= s6_nxx;
      s7_nyy <= s6_nyy;
      s7_nxy <= s6_nxy;
      s7_wad <= s6_wad;
      s7_wae <= s6_wae;

      sd[1] <= s7_sd;
      for (int k = 2; k <= DIV_LAT; k++) begin
        sd[k] <= sd[k-1];
      end

      cd[0] <= cost_log;
      for (int k = 1; k < COST_DLY; k++) begin
        cd[k] <= cd[k-1];
      end
    end
  end

  plbq_div #(.NW(98), .DW(100), .QW(DIV_QW)) u_div_xx (
    .clk(clk), .en(en), .num(s7_nxx), .den(s7_g2), .quo(q_xx));
  plbq_div #(.NW(98), .DW(100), .QW(DIV_QW)) u_div_yy (
    .clk(clk), .en(en), .num(s7_nyy), .den(s7_g2), .quo(q_yy));
  plbq_div #(.NW(98), .DW(100), .QW(DIV_QW)) u_div_xy (
    .clk(clk), .en(en), .num(s7_nxy), .den(s7_g2), .quo(q_xy));
  plbq_div #(.NW(64), .DW(50), .QW(DIV_QW)) u_div_gx (
    .clk(clk), .en(en), .num(s7_wad), .den(s7_g), .quo(q_gx));
  plbq_div #(.NW(64), .DW(50), .QW(DIV_QW)) u_div_gy (
    .clk(clk), .en(en), .num(s7_wae), .den(s7_g), .quo(q_gy));
  plbq_div #(.NW(64), .DW(50), .QW(DIV_QW)) u_div_w (
    .clk(clk), .en(en), .num(64'({weight, 16'b0})), .den(s7_g), .quo(q_w));

  plbq_log u_log (
    .clk(clk), .en(en), .g(s7_g), .w(weight), .cost(cost_log));

  assign sl = sd[DIV_LAT];
  assign hx = (q_xx >= q_w) ? sat48(1'b0, q_xx - q_w) : sat48(1'b1, q_w - q_xx);
  assign hy = (q_yy >= q_w) ? sat48(1'b0, q_yy - q_w) : sat48(1'b1, q_w - q_yy);

  always_comb begin
    fin.gap_invalid = sl.inv;
    if (sl.inv) begin
      fin.cost    = '0;
      fin.hess_xx = '0;
      fin.hess_yy = '0;
      fin.hess_xy = '0;
      fin.grad_x  = '0;
      fin.grad_y  = '0;
    end else begin
      fin.cost    = cd[COST_DLY-1];
      fin.hess_xx = hx;
      fin.hess_yy = hy;
      fin.hess_xy = sat48((sl.dneg != sl.eneg) && !sl.dzero && !sl.ezero, q_xy);
      fin.grad_x  = sat48(!sl.dneg && !sl.dzero, q_gx);
      fin.grad_y  = sat48(!sl.eneg && !sl.ezero, q_gy);
    end
  end

  assign push = en && vp[PIPE_LAT-1];
  assign pop  = res.valid && res.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else begin
      cnt <= cnt + 2'(push) - 2'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push && ((cnt - 2'(pop)) == 2'd0)) begin
      buf0 <= fin;
    end else if (pop) begin
      buf0 <= buf1;
    end
    if (push && ((cnt - 2'(pop)) != 2'd0)) begin
      buf1 <= fin;
    end
  end

  assign res.valid       = cnt != 2'd0;
  assign res.cost        = $signed(buf0.cost);
  assign res.hess_xx     = $signed(buf0.hess_xx);
  assign res.hess_yy     = $signed(buf0.hess_yy);
  assign res.hess_xy     = $signed(buf0.hess_xy);
  assign res.grad_x      = $signed(buf0.grad_x);
  assign res.grad_y      = $signed(buf0.grad_y);
  assign res.gap_invalid = buf0.gap_invalid;

  a_cnt_range: assert property (@(posedge clk) disable iff (rst) cnt != 2'd3)
    else $error("output buffer count out of range");

  a_push_shows: assert property (@(posedge clk) disable iff (rst)
    push |=> res.valid)
    else $error("pushed result not visible");

  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    !en |=> $stable(vp))
    else $error("pipeline moved while stalled");

  a_invalid_zero: assert property (@(posedge clk) disable iff (rst)
    (res.valid && res.gap_invalid) |-> (res.cost == 0 && res.hess_xx == 0 &&
      res.hess_yy == 0 && res.hess_xy == 0 && res.grad_x == 0 && res.grad_y == 0))
    else $error("invalid gap with nonzero terms");

endmodule

>>> test/tb_proximity_log_barrier_quadratic.sv
// Testbench for proximity_log_barrier_quadratic: a directed table, then random pairs
// of positions over several weight and threshold settings, checked against a predictor.
// Depends on plbq_pkg, plbq_if and the block's RTL.
`timescale 1ns / 1ps

module tb_proximity_log_barrier_quadratic;
  import plbq_pkg::*;

  localparam logic [CFG_IW-1:0] REG_SPARE = 2'd2;
  localparam int LIMIT = 400000;
  localparam int HOLD_LEN = 300;
  localparam int RAND_PER_PHASE = 100;
  localparam int NUM_PHASES = 6;
  localparam res_t GAP_BAD = 289'd1;
  localparam res_t NO_RES = '0;

  typedef struct packed {
    logic [31:0] fx, fy, sx, sy;
    logic        known;
    res_t        want;
  } pair_row_t;

  localparam int NUM_ROWS = 16;
  localparam pair_row_t PAIR_TAB [NUM_ROWS] = '{
    '{32'h0, 32'h0, 32'h0, 32'h0, 1'b1, GAP_BAD},
    '{32'h0005_0000, 32'hFFFD_0000, 32'h0005_0000, 32'hFFFD_0000, 1'b1, GAP_BAD},
    '{32'h0001_0000, 32'h0, 32'h0, 32'h0, 1'b1, GAP_BAD},
    '{32'h0, 32'h0000_0001, 32'h0, 32'h0, 1'b1, GAP_BAD},
    '{32'h0001_0001, 32'h0, 32'h0, 32'h0, 1'b0, NO_RES},
    '{32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 1'b0, NO_RES},
    '{32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0, NO_RES},
    '{32'h7FFF_FFFF, 32'h0, 32'h0, 32'h0, 1'b0, NO_RES},
    '{32'h0, 32'h8000_0000, 32'h0, 32'h0, 1'b0, NO_RES},
    '{32'h0002_0000, 32'h0, 32'h0, 32'h0, 1'b0, NO_RES},
    '{32'hFFFE_0000, 32'h0, 32'h0, 32'h0, 1'b0, NO_RES},
    '{32'h0, 32'h0003_0000, 32'h0, 32'h0, 1'b0, NO_RES},
    '{32'h0001_8000, 32'h0, 32'h0, 32'h0001_8000, 1'b0, NO_RES},
    '{32'hFFFF_4000, 32'hFFFD_C000, 32'h0, 32'h0, 1'b0, NO_RES},
    '{32'h03E8_0000, 32'hFC18_0000, 32'h0, 32'h0, 1'b0, NO_RES},
    '{32'h0001_0000, 32'h0001_0000, 32'h0, 32'h0, 1'b0, NO_RES}
  };

  logic clk = 1'b0;
  logic rst = 1'b1;
  int   errors = 0;
  int   n_items = 0;
  int   n_results = 0;
  int   n_gap_bad = 0;
  int   cycles = 0;
  int   send_idle = 0;
  int   recv_idle = 0;
  int   hold_req = 0;
  int   hold_done = 0;
  logic [63:0] weight_q = 64'(WEIGHT_RST);
  logic [63:0] thresh_q = 64'(THRESH_RST);
  res_t barrier_q[$];

  plbq_in_if  pos_if();
  plbq_out_if res_if();
  plbq_cfg_if cfg_if();

  proximity_log_barrier_quadratic DUT (
    .clk(clk), .rst(rst), .pos(pos_if), .res(res_if), .cfg(cfg_if)
  );

  always #6 clk = ~clk;

  function automatic logic [47:0] clamp48(input bit neg, input logic [127:0] mag);
    logic [127:0] cap;
    logic [47:0]  v;
    cap = neg ? 128'h8000_0000_0000 : 128'h7FFF_FFFF_FFFF;
    v = (mag > cap) ? cap[47:0] : mag[47:0];
    return neg ? 48'd0 - v : v;
  endfunction

  function automatic logic [47:0] barrier_cost(input logic [63:0] w, input logic [63:0] g);
    int p;
    logic [63:0] m, frac, lmag, lnmag;
    longint l;
    p = 0;
    for (int i = 0; i < 64; i++) if (g[i]) p = i;
    m = (p <= 30) ? g << (30 - p) : g >> (p - 30);
    frac = 0;
    for (int i = 0; i < 24; i++) begin
      m = (m * m) >> 30;
      frac = frac << 1;
      if (m >= (64'd2 << 30)) begin
        m = m >> 1;
        frac = frac | 64'd1;
      end
    end
    l = longint'(p - 16) * (longint'(1) << 24) + longint'(frac);
    lmag = (l < 0) ? 64'(-l) : 64'(l);
    lnmag = (lmag * 64'(LN2_Q32)) >> 32;
    return clamp48(l >= 0 && lnmag != 0, 128'((w * lnmag) >> 25));
  endfunction

  function automatic logic [127:0] curvature(input logic [63:0] w, a, b,
                                             input logic [127:0] g2);
    logic [127:0] n;
    n = 128'(a) * 128'(b) * 128'(w);
    return (n << 1) / g2;
  endfunction

  function automatic logic [47:0] hess_diag(input logic [63:0] w, a, g,
                                            input logic [127:0] g2);
    logic [127:0] p, q;
    p = curvature(w, a, a, g2);
    q = 128'((w << 16) / g);
    return (p >= q) ? clamp48(1'b0, p - q) : clamp48(1'b1, q - p);
  endfunction

  function automatic res_t predict_barrier(input logic signed [31:0] fx, fy, sx, sy);
    longint d, e;
    logic [63:0]  ad, ae, sum, g;
    logic [127:0] s, g2;
    res_t r;
    d = longint'(fx) - longint'(sx);
    e = longint'(fy) - longint'(sy);
    ad = (d < 0) ? 64'(-d) : 64'(d);
    ae = (e < 0) ? 64'(-e) : 64'(e);
    s = 128'(ad) * 128'(ad) + 128'(ae) * 128'(ae);
    sum = s[79:16];
    if (sum <= thresh_q) return GAP_BAD;
    g = sum - thresh_q;
    g2 = 128'(g) * 128'(g);
    r.cost = barrier_cost(weight_q, g);
    r.hess_xx = hess_diag(weight_q, ad, g, g2);
    r.hess_yy = hess_diag(weight_q, ae, g, g2);
    r.hess_xy = clamp48((d < 0) != (e < 0) && ad != 0 && ae != 0,
                        curvature(weight_q, ad, ae, g2));
    r.grad_x = clamp48(d > 0, (128'(weight_q) * 128'(ad)) / 128'(g));
    r.grad_y = clamp48(e > 0, (128'(weight_q) * 128'(ae)) / 128'(g));
    r.gap_invalid = 1'b0;
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [47:0] got, exp);
    $display("MISMATCH %s: got %h, expected %h at cycle %0d", what, got, exp, cycles);
    errors++;
  endtask

  task automatic send_pair(input logic [31:0] fx, fy, sx, sy, input bit known,
                           input res_t want);
    while ($urandom_range(0, 99) < send_idle) begin
      pos_if.valid <= 1'b0;
      @(negedge clk);
    end
    pos_if.valid <= 1'b1;
    pos_if.first_x <= fx;
    pos_if.first_y <= fy;
    pos_if.second_x <= sx;
    pos_if.second_y <= sy;
    do @(posedge clk); while (!pos_if.ready);
    barrier_q.push_back(known ? want : predict_barrier(fx, fy, sx, sy));
    n_items++;
    @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IW-1:0] idx, input logic [47:0] val);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data <= val;
    do @(posedge clk); while (!cfg_if.ready);
    if (idx == REG_WEIGHT) weight_q = 64'(val[31:0]);
    else if (idx == REG_THRESH) thresh_q = 64'(val);
    @(negedge clk);
    cfg_if.valid <= 1'b0;
  endtask

  task automatic drain;
    pos_if.valid <= 1'b0;
    while (barrier_q.size() != 0) @(negedge clk);
  endtask

  task automatic random_pair;
    logic [31:0] fx, fy, sx, sy;
    int sel;
    sel = $urandom_range(0, 9);
    fx = $urandom;
    fy = $urandom;
    if (sel < 2) begin
      sx = $urandom;
      sy = $urandom;
    end else if (sel == 2) begin
      sx = fx;
      sy = fy;
    end else if (sel < 9) begin
      sx = fx + $urandom_range(0, 32'h8_0000) - 32'h4_0000;
      sy = fy + $urandom_range(0, 32'h8_0000) - 32'h4_0000;
    end else begin
      sx = fx + $urandom_range(0, 32'h200_0000) - 32'h100_0000;
      sy = fy + $urandom_range(0, 32'h200_0000) - 32'h100_0000;
    end
    send_pair(fx, fy, sx, sy, 1'b0, NO_RES);
  endtask

  initial begin
    res_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req > hold_done) begin
        res_if.ready <= 1'b0;
        repeat (HOLD_LEN - 1) @(negedge clk);
        hold_done++;
      end else begin
        res_if.ready <= ($urandom_range(0, 99) >= recv_idle);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && res_if.valid && res_if.ready) begin
      if (barrier_q.size() == 0) begin
        report_mismatch("unexpected result", res_if.cost, '0);
      end else begin
        res_t exp;
        exp = barrier_q.pop_front();
        n_results++;
        if (res_if.gap_invalid) n_gap_bad++;
        if (res_if.cost !== exp.cost) report_mismatch("cost", res_if.cost, exp.cost);
        if (res_if.hess_xx !== exp.hess_xx)
          report_mismatch("hess_xx", res_if.hess_xx, exp.hess_xx);
        if (res_if.hess_yy !== exp.hess_yy)
          report_mismatch("hess_yy", res_if.hess_yy, exp.hess_yy);
        if (res_if.hess_xy !== exp.hess_xy)
          report_mismatch("hess_xy", res_if.hess_xy, exp.hess_xy);
        if (res_if.grad_x !== exp.grad_x)
          report_mismatch("grad_x", res_if.grad_x, exp.grad_x);
        if (res_if.grad_y !== exp.grad_y)
          report_mismatch("grad_y", res_if.grad_y, exp.grad_y);
        if (res_if.gap_invalid !== exp.gap_invalid)
          report_mismatch("gap_invalid", 48'(res_if.gap_invalid), 48'(exp.gap_invalid));
      end
    end
  end

  initial begin
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > LIMIT) begin
        $display("timeout after %0d cycles, %0d results outstanding", cycles,
                 barrier_q.size());
        $display("[proximity_log_barrier_quadratic] ERROR");
        $finish;
      end
    end
  end

  initial begin
    logic [31:0] phase_w [NUM_PHASES];
    logic [47:0] phase_t [NUM_PHASES];
    phase_w = '{32'h0001_0000, 32'h0, 32'hFFFF_FFFF, 32'h0000_8000, 32'h0003_0000,
                32'h0000_0001};
    phase_t = '{48'h1_0000, 48'h1_0000, 48'h0, 48'hFFFF_FFFF_FFFF, 48'h4_0000, 48'h1};
    pos_if.valid = 1'b0;
    pos_if.first_x = '0;
    pos_if.first_y = '0;
    pos_if.second_x = '0;
    pos_if.second_y = '0;
    cfg_if.valid = 1'b0;
    cfg_if.index = '0;
    cfg_if.data = '0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    for (int i = 0; i < NUM_ROWS; i++)
      send_pair(PAIR_TAB[i].fx, PAIR_TAB[i].fy, PAIR_TAB[i].sx, PAIR_TAB[i].sy,
                PAIR_TAB[i].known, PAIR_TAB[i].want);

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      drain();
      repeat (4) @(negedge clk);
      if (ph == NUM_PHASES - 1) write_reg(REG_SPARE, 48'hFFFF_FFFF_FFFF);
      write_reg(REG_WEIGHT, {16'hABCD, phase_w[ph]});
      write_reg(REG_THRESH, phase_t[ph]);
      send_idle = (ph < 2) ? 29 : (ph < 4) ? 71 : 0;
      recv_idle = (ph < 2) ? 71 : (ph < 4) ? 29 : 0;
      if (ph == 4) hold_req++;
      for (int k = 0; k < RAND_PER_PHASE; k++) begin
        if (ph == 3 && k == RAND_PER_PHASE / 2) drain();
        random_pair();
      end
    end

    drain();
    repeat (PIPE_LAT + 20) @(negedge clk);
    $display("Sent %0d position pairs over %0d register settings; %0d results checked,",
             n_items, NUM_PHASES, n_results);
    $display("%0d of them with a non-positive gap.", n_gap_bad);
    if (errors == 0 && barrier_q.size() == 0) begin
      $display("[proximity_log_barrier_quadratic] OK");
    end else begin
      $display("%0d mismatches, %0d results never arrived", errors, barrier_q.size());
      $display("[proximity_log_barrier_quadratic] ERROR");
    end
    $finish;
  end

endmodule
